>>> rtl/core/abr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AXI write burst router package
// Shared types, codes and helper functions for the router front, queue and
// back end.
// ----------------------------------------------------------------------------
package abr_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned QOS_W   = 4;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned PLANE_W = 3;
  localparam int unsigned BEATS_W = 9;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ROUTE_W = PLANE_W + BEATS_W;

  // Default sizes
  localparam int unsigned ROUTE_DEPTH_DEF = 16;
  localparam int unsigned MAX_PLANES_DEF  = 8;
  localparam int unsigned OPQ_DEPTH       = 2;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_AW = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AR = 2'd2;

  // Reset value of the plane count register
  localparam logic [CNT_W-1:0] PLANE_COUNT_RST = 4'd1;

  // Classified operation kinds
  typedef enum logic [1:0] {
    OP_AW,
    OP_WB,
    OP_AR,
    OP_NOP
  } op_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOROUTE
  } status_e;

  // Back end sequencer states
  typedef enum logic {
    BK_RUN,
    BK_POP
  } back_state_e;

  // One classified operation, as held in the operation queue
  typedef struct packed {
    op_kind_e             kind;
    logic [PLANE_W-1:0]   plane;
    logic [BEATS_W-1:0]   beats;
    logic                 last;
  } op_t;

  // One result, as registered toward the output ports
  typedef struct packed {
    logic                 valid;
    logic [PLANE_W-1:0]   plane;
    status_e              status;
    logic                 burst_end;
    logic                 mismatch;
  } result_t;

  // Remainder of a QoS value by a small plane count (1 to 16), computed as a
  // four step restoring reduction on narrow values.
  function automatic logic [QOS_W-1:0] qos_mod(input logic [QOS_W-1:0] qos,
                                                input logic [4:0] n);
    logic [8:0] rem;
    logic [8:0] sub;
    rem = {5'd0, qos};
    for (int k = 3; k >= 0; k--) begin
      sub = {4'd0, n} << k;
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    return rem[QOS_W-1:0];
  endfunction

endpackage

>>> rtl/core/abr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module abr_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/abr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router front end
// Holds the plane count register, accepts commands, maps QoS to a plane and
// classifies each item into an operation for the queue.
// ----------------------------------------------------------------------------
module abr_front #(
  parameter int unsigned MAX_PLANES = abr_pkg::MAX_PLANES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [abr_pkg::CMD_W-1:0]   cmd_i,
  input  logic [abr_pkg::QOS_W-1:0]   qos_i,
  input  logic [abr_pkg::LEN_W-1:0]   burst_len_i,
  input  logic                        w_last_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [abr_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        opq_full_i,
  output logic                        push_o,
  output abr_pkg::op_t                op_o
);

  localparam logic [4:0] MaxPlanes = 5'(MAX_PLANES);

  logic [abr_pkg::CNT_W-1:0] plane_count_q;
  logic [abr_pkg::CNT_W-1:0] plane_count_d;
  logic [4:0]                eff_count;
  logic [abr_pkg::QOS_W-1:0] qos_rem;

  // Configuration register: a write transfer is taken every cycle
  assign cfg_ready_o   = 1'b1;
  assign plane_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : plane_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= abr_pkg::PLANE_COUNT_RST;
    end else begin
      plane_count_q <= plane_count_d;
    end
  end

  // Effective plane count: zero counts as one, large values saturate.
  always_comb begin
    eff_count = {1'b0, plane_count_q};
    if (eff_count == 5'd0) begin
      eff_count = 5'd1;
    end else if (eff_count > MaxPlanes) begin
      eff_count = MaxPlanes;
    end
  end

  assign qos_rem = abr_pkg::qos_mod(qos_i, eff_count);

  // Items are taken whenever the operation queue has room.
  assign busy   = opq_full_i;
  assign push_o = start && !busy;

  // Classify the command.
  always_comb begin
    op_o.plane = qos_rem[abr_pkg::PLANE_W-1:0];
    op_o.beats = abr_pkg::BEATS_W'({1'b0, burst_len_i} + 9'd1);
    op_o.last  = w_last_i;
    case (cmd_i)
      abr_pkg::CMD_AW: op_o.kind = abr_pkg::OP_AW;
      abr_pkg::CMD_WB: op_o.kind = abr_pkg::OP_WB;
      abr_pkg::CMD_AR: op_o.kind = abr_pkg::OP_AR;
      default:         op_o.kind = abr_pkg::OP_NOP;
    endcase
  end

endmodule

>>> rtl/core/abr_opq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module abr_opq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  abr_pkg::op_t op_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         full_o,
  output abr_pkg::op_t op_o
);

  localparam int unsigned Depth = abr_pkg::OPQ_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  abr_pkg::op_t  slot_q [Depth];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign op_o    = slot_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> rtl/core/abr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router back end
// Executes queued operations against the route queue and the held route, and
// registers one result per operation.
// ----------------------------------------------------------------------------
module abr_back #(
  parameter int unsigned ROUTE_DEPTH = abr_pkg::ROUTE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  abr_pkg::op_t     op_i,
  output logic             op_pop_o,
  output abr_pkg::result_t result_o
);

  localparam int unsigned PtrW  = $clog2(ROUTE_DEPTH);
  localparam int unsigned FillW = $clog2(ROUTE_DEPTH + 1);

  abr_pkg::back_state_e state_q, state_d;

  logic [PtrW-1:0]             head_q, head_d;
  logic [PtrW-1:0]             tail_q, tail_d;
  logic [FillW-1:0]            fill_q, fill_d;
  logic [abr_pkg::PLANE_W-1:0] cur_plane_q, cur_plane_d;
  logic [abr_pkg::BEATS_W-1:0] beats_q, beats_d;
  logic                        held_q, held_d;
  abr_pkg::result_t            res_q, res_d;

  logic                        ram_we;
  logic                        ram_re;
  logic [abr_pkg::ROUTE_W-1:0] ram_wdata;
  logic [abr_pkg::ROUTE_W-1:0] ram_rdata;

  logic                        need_fetch;
  logic [abr_pkg::PLANE_W-1:0] src_plane;
  logic [abr_pkg::BEATS_W-1:0] src_beats;
  logic [abr_pkg::BEATS_W-1:0] beats_dec;
  logic                        count_done;
  logic                        beat_end;
  logic                        beat_mism;

  // Route queue storage
  abr_ram #(
    .WIDTH (abr_pkg::ROUTE_W),
    .DEPTH (ROUTE_DEPTH)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {op_i.plane, op_i.beats};

  // A data beat without a held route must first read the oldest route.
  assign need_fetch = (state_q == abr_pkg::BK_RUN) && op_valid_i &&
                      (op_i.kind == abr_pkg::OP_WB) && !held_q && (fill_q != '0);

  // Beat accounting on the held route or on the route just read.
  assign src_plane  = (state_q == abr_pkg::BK_POP) ?
                      ram_rdata[abr_pkg::ROUTE_W-1:abr_pkg::BEATS_W] : cur_plane_q;
  assign src_beats  = (state_q == abr_pkg::BK_POP) ?
                      ram_rdata[abr_pkg::BEATS_W-1:0] : beats_q;
  assign beats_dec  = (src_beats != '0) ? src_beats - abr_pkg::BEATS_W'(1) : '0;
  assign count_done = (beats_dec == '0);
  assign beat_mism  = (count_done != op_i.last);
  assign beat_end   = count_done || op_i.last;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      abr_pkg::BK_RUN: begin
        if (need_fetch) begin
          state_d = abr_pkg::BK_POP;
        end
      end
      abr_pkg::BK_POP: begin
        state_d = abr_pkg::BK_RUN;
      end
      default: begin
        state_d = abr_pkg::BK_RUN;
      end
    endcase
  end

  // Operation execution and result formation
  always_comb begin
    op_pop_o       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    head_d         = head_q;
    tail_d         = tail_q;
    fill_d         = fill_q;
    cur_plane_d    = cur_plane_q;
    beats_d        = beats_q;
    held_d         = held_q;
    res_d.valid    = 1'b0;
    res_d.plane    = '0;
    res_d.status   = abr_pkg::ST_OK;
    res_d.burst_end = 1'b0;
    res_d.mismatch = 1'b0;
    case (state_q)
      abr_pkg::BK_RUN: begin
        if (op_valid_i) begin
          case (op_i.kind)
            abr_pkg::OP_AW: begin
              op_pop_o    = 1'b1;
              res_d.valid = 1'b1;
              if (fill_q == FillW'(ROUTE_DEPTH)) begin
                res_d.status = abr_pkg::ST_FULL;
              end else begin
                ram_we      = 1'b1;
                res_d.plane = op_i.plane;
                tail_d      = (tail_q == PtrW'(ROUTE_DEPTH - 1)) ? '0 :
                              tail_q + PtrW'(1);
                fill_d      = fill_q + FillW'(1);
              end
            end
            abr_pkg::OP_AR: begin
              op_pop_o    = 1'b1;
              res_d.valid = 1'b1;
              res_d.plane = op_i.plane;
            end
            abr_pkg::OP_WB: begin
              if (held_q) begin
                op_pop_o        = 1'b1;
                res_d.valid     = 1'b1;
                res_d.plane     = src_plane;
                res_d.burst_end = beat_end;
                res_d.mismatch  = beat_mism;
                beats_d         = beats_dec;
                held_d          = !beat_end;
              end else if (fill_q != '0) begin
                ram_re = 1'b1;
              end else begin
                op_pop_o     = 1'b1;
                res_d.valid  = 1'b1;
                res_d.status = abr_pkg::ST_NOROUTE;
              end
            end
            default: begin
              op_pop_o    = 1'b1;
              res_d.valid = 1'b1;
            end
          endcase
        end
      end
      abr_pkg::BK_POP: begin
        // Route read last cycle: take it and serve the waiting beat.
        op_pop_o        = 1'b1;
        head_d          = (head_q == PtrW'(ROUTE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
        fill_d          = fill_q - FillW'(1);
        cur_plane_d     = src_plane;
        beats_d         = beats_dec;
        held_d          = !beat_end;
        res_d.valid     = 1'b1;
        res_d.plane     = src_plane;
        res_d.burst_end = beat_end;
        res_d.mismatch  = beat_mism;
      end
      default: begin
        op_pop_o = 1'b0;
      end
    endcase
  end

  // Control and route state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abr_pkg::BK_RUN;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      cur_plane_q <= '0;
      beats_q     <= '0;
      held_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      cur_plane_q <= cur_plane_d;
      beats_q     <= beats_d;
      held_q      <= held_d;
      res_q       <= res_d;
    end
  end

  assign result_o = res_q;

  // The route queue never holds more entries than it has.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(ROUTE_DEPTH))
    else $error("route queue fill exceeds depth");

  // A route read is only issued with a queued route and none held.
  a_pop_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abr_pkg::BK_POP) |-> (fill_q != '0) && !held_q)
    else $error("route read without a queued route");

  // The read stage always returns straight to the run state.
  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abr_pkg::BK_POP) |=> (state_q == abr_pkg::BK_RUN))
    else $error("route read stage did not return");

  // A held route always has beats outstanding.
  a_held_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (beats_q != '0))
    else $error("held route with no beats left");

  // A write into the route queue never lands on a full queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (fill_q < FillW'(ROUTE_DEPTH)))
    else $error("route queue written while full");

endmodule

>>> rtl/core/axi_write_burst_router_unit.sv
`timescale 1ns / 1ps
// Path: command, operation queue, back end result register; a data beat
//   that has to read its route also passes the route queue memory read port.
// Throughput: one command per cycle while the operation queue has room; a
//   beat that opens a route stalls the back end for the registered read.
// Reset clears all control state and sets the plane count to 1; the route
//   queue memory itself is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
// AXI write burst router
// Maps AXI address QoS to planes, queues write routes and steers write data
// beats along them, through a front end, an operation queue and a back end.
// ----------------------------------------------------------------------------
module axi_write_burst_router_unit #(
  parameter int unsigned ROUTE_DEPTH = abr_pkg::ROUTE_DEPTH_DEF,
  parameter int unsigned MAX_PLANES  = abr_pkg::MAX_PLANES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [abr_pkg::CMD_W-1:0]     cmd_i,
  input  logic [abr_pkg::QOS_W-1:0]     qos_i,
  input  logic [abr_pkg::LEN_W-1:0]     burst_len_i,
  input  logic                          w_last_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [abr_pkg::CNT_W-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic [abr_pkg::PLANE_W-1:0]   plane_o,
  output logic [1:0]                    status_o,
  output logic                          burst_end_o,
  output logic                          last_mismatch_o
);

  logic             push;
  logic             opq_full;
  logic             opq_valid;
  logic             opq_pop;
  abr_pkg::op_t     op_in;
  abr_pkg::op_t     op_head;
  abr_pkg::result_t result;

  // Command intake and classification
  abr_front #(
    .MAX_PLANES (MAX_PLANES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .qos_i       (qos_i),
    .burst_len_i (burst_len_i),
    .w_last_i    (w_last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .opq_full_i  (opq_full),
    .push_o      (push),
    .op_o        (op_in)
  );

  // Decoupling queue between front and back
  abr_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .pop_i   (opq_pop),
    .valid_o (opq_valid),
    .full_o  (opq_full),
    .op_o    (op_head)
  );

  // Route execution
  abr_back #(
    .ROUTE_DEPTH (ROUTE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (opq_valid),
    .op_i       (op_head),
    .op_pop_o   (opq_pop),
    .result_o   (result)
  );

  // Result ports
  assign result_valid_o  = result.valid;
  assign plane_o         = result.plane;
  assign status_o        = result.status;
  assign burst_end_o     = result.burst_end;
  assign last_mismatch_o = result.mismatch;

endmodule
